// ===== src/ttcw_pkg.sv =====
// ----------------------------------------------------------------------------
// ttcw_pkg
// Shared types, constants and helpers of the text terminal cursor writer.
// ----------------------------------------------------------------------------
package ttcw_pkg;

  localparam int ROWS   = 25;
  localparam int COLS   = 80;
  localparam int TOTAL  = ROWS * COLS;
  localparam int ADDR_W = $clog2(TOTAL + 1);
  localparam int RAM_AW = $clog2(TOTAL);
  localparam int CELL_W = 16;

  localparam int ACTION_W = 3;
  localparam int BYTE_W   = 8;
  localparam int POSCOL_W = 7;
  localparam int POSROW_W = 6;
  localparam int CURCOL_W = 7;
  localparam int CURROW_W = 5;

  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [BYTE_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 3'd0,
    ACT_POS   = 3'd1,
    ACT_SETC  = 3'd2,
    ACT_CLEAR = 3'd3,
    ACT_READ  = 3'd4
  } act_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_POS_WRITE,
    OP_SET_CURSOR,
    OP_CLEAR_ALL,
    OP_READ_REQ,
    OP_READ_CAP,
    OP_SCROLL_INIT,
    OP_SCROLL_RD,
    OP_SCROLL_WR,
    OP_BOTTOM_INIT,
    OP_CLEAR_STEP,
    OP_PUT,
    OP_LOAD_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    act_t                action;
    logic                on_screen;
    logic                scroll_pending;
    logic                sweep_done;
    logic                put_clears;
    logic                out_free;
    logic [CURCOL_W-1:0] cur_col;
    logic [CURROW_W-1:0] cur_row;
  } sts_t;

  // Linear cell index of a row and column.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [POSROW_W-1:0] row,
                                                  input logic [POSCOL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(COLS) + ADDR_W'(col);
  endfunction

endpackage

// ===== src/ttcw_if.sv =====
// ----------------------------------------------------------------------------
// ttcw_if
// Valid/ready channels of the text terminal cursor writer.
// ----------------------------------------------------------------------------
interface ttcw_in_if;
  logic                            valid;
  logic                            ready;
  logic [ttcw_pkg::ACTION_W-1:0]   action;
  logic [ttcw_pkg::BYTE_W-1:0]     char_code;
  logic [ttcw_pkg::BYTE_W-1:0]     color;
  logic [ttcw_pkg::POSCOL_W-1:0]   pos_col;
  logic [ttcw_pkg::POSROW_W-1:0]   pos_row;

  modport source (output valid, action, char_code, color, pos_col, pos_row, input ready);
  modport sink   (input valid, action, char_code, color, pos_col, pos_row, output ready);
endinterface

interface ttcw_out_if;
  logic                            valid;
  logic                            ready;
  logic [ttcw_pkg::BYTE_W-1:0]     cell_char;
  logic [ttcw_pkg::BYTE_W-1:0]     cell_color;
  logic [ttcw_pkg::CURCOL_W-1:0]   cursor_col;
  logic [ttcw_pkg::CURROW_W-1:0]   cursor_row;
  logic                            position_error;

  modport source (output valid, cell_char, cell_color, cursor_col, cursor_row,
                  position_error, input ready);
  modport sink   (input valid, cell_char, cell_color, cursor_col, cursor_row,
                  position_error, output ready);
endinterface

// ===== src/ttcw_ram.sv =====
// ----------------------------------------------------------------------------
// ttcw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ttcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ttcw_dp.sv =====
// ----------------------------------------------------------------------------
// ttcw_dp
// Datapath: item register, cursor, sweep counter, screen memory, result.
// ----------------------------------------------------------------------------
module ttcw_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ttcw_pkg::cmd_t                  cmd,
  output ttcw_pkg::sts_t                  sts,
  input  logic [ttcw_pkg::ACTION_W-1:0]   in_action,
  input  logic [ttcw_pkg::BYTE_W-1:0]     in_char_code,
  input  logic [ttcw_pkg::BYTE_W-1:0]     in_color,
  input  logic [ttcw_pkg::POSCOL_W-1:0]   in_pos_col,
  input  logic [ttcw_pkg::POSROW_W-1:0]   in_pos_row,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [ttcw_pkg::BYTE_W-1:0]     out_cell_char,
  output logic [ttcw_pkg::BYTE_W-1:0]     out_cell_color,
  output logic [ttcw_pkg::CURCOL_W-1:0]   out_cursor_col,
  output logic [ttcw_pkg::CURROW_W-1:0]   out_cursor_row,
  output logic                            out_position_error
);

  localparam int AW  = ttcw_pkg::ADDR_W;
  localparam int CW  = ttcw_pkg::CURCOL_W;
  localparam int RW  = ttcw_pkg::CURROW_W;
  localparam int BW  = ttcw_pkg::BYTE_W;

  // Item register.
  logic [ttcw_pkg::ACTION_W-1:0] item_action_r;
  logic [BW-1:0]                 item_char_r, item_color_r;
  logic [ttcw_pkg::POSCOL_W-1:0] item_col_r;
  logic [ttcw_pkg::POSROW_W-1:0] item_row_r;

  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW-1:0] lim_r, lim_nxt;

  logic [BW-1:0] res_char_r, res_char_nxt;
  logic [BW-1:0] res_color_r, res_color_nxt;
  logic          res_err_r, res_err_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [BW-1:0] out_char_r, out_color_r;
  logic [CW-1:0] out_col_r;
  logic [RW-1:0] out_row_r;
  logic          out_err_r;

  logic                          ram_we, ram_re;
  logic [ttcw_pkg::RAM_AW-1:0]   ram_waddr, ram_raddr;
  logic [ttcw_pkg::CELL_W-1:0]   ram_wdata, ram_rdata;

  logic          is_newline, is_return, is_backspace, is_ctrl, on_screen;
  logic [CW-1:0] col_eff;
  logic [AW-1:0] put_addr, pos_addr, row_next_base, line_lim;

  assign is_newline   = (item_char_r == ttcw_pkg::CH_NEWLINE);
  assign is_return    = (item_char_r == ttcw_pkg::CH_RETURN);
  assign is_backspace = (item_char_r == ttcw_pkg::CH_BACKSPACE);
  assign is_ctrl      = is_newline | is_return | is_backspace;
  assign on_screen    = (item_col_r < ttcw_pkg::COLS) && (item_row_r < ttcw_pkg::ROWS);

  assign col_eff  = (cur_col_r >= ttcw_pkg::COLS) ? CW'(ttcw_pkg::COLS - 1) : cur_col_r;
  assign put_addr = ttcw_pkg::cell_addr({1'b0, cur_row_r}, col_eff);
  assign pos_addr = ttcw_pkg::cell_addr(item_row_r, item_col_r);
  assign row_next_base = ttcw_pkg::cell_addr({1'b0, cur_row_r} + 6'd1, 7'd0);
  // The row after the next one would lie past the screen on the last row.
  assign line_lim = (cur_row_r == RW'(ttcw_pkg::ROWS - 1)) ? AW'(ttcw_pkg::TOTAL) :
                    ttcw_pkg::cell_addr({1'b0, cur_row_r} + 6'd2, 7'd0);

  always_comb begin
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    addr_nxt      = addr_r;
    lim_nxt       = lim_r;
    res_char_nxt  = res_char_r;
    res_color_nxt = res_color_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    unique case (cmd.op)
      ttcw_pkg::OP_NONE: begin
      end
      ttcw_pkg::OP_LATCH: begin
        res_char_nxt  = '0;
        res_color_nxt = '0;
        res_err_nxt   = 1'b0;
      end
      ttcw_pkg::OP_POS_WRITE: begin
        if (!on_screen) begin
          res_err_nxt = 1'b1;
        end else if (!is_ctrl) begin
          ram_we    = 1'b1;
          ram_waddr = pos_addr[ttcw_pkg::RAM_AW-1:0];
          ram_wdata = {item_color_r, item_char_r};
        end
      end
      ttcw_pkg::OP_SET_CURSOR: begin
        res_err_nxt = ~on_screen;
        cur_col_nxt = (item_col_r < ttcw_pkg::COLS) ? CW'(item_col_r) :
                      CW'(ttcw_pkg::COLS - 1);
        cur_row_nxt = (item_row_r < ttcw_pkg::ROWS) ? RW'(item_row_r) :
                      RW'(ttcw_pkg::ROWS - 1);
      end
      ttcw_pkg::OP_CLEAR_ALL: begin
        addr_nxt    = '0;
        lim_nxt     = AW'(ttcw_pkg::TOTAL);
        cur_col_nxt = '0;
        cur_row_nxt = '0;
      end
      ttcw_pkg::OP_READ_REQ: begin
        if (on_screen) begin
          ram_re    = 1'b1;
          ram_raddr = pos_addr[ttcw_pkg::RAM_AW-1:0];
        end else begin
          res_err_nxt = 1'b1;
        end
      end
      ttcw_pkg::OP_READ_CAP: begin
        res_char_nxt  = ram_rdata[BW-1:0];
        res_color_nxt = ram_rdata[2*BW-1:BW];
      end
      ttcw_pkg::OP_SCROLL_INIT: begin
        addr_nxt = '0;
        lim_nxt  = AW'((ttcw_pkg::ROWS - 1) * ttcw_pkg::COLS);
      end
      ttcw_pkg::OP_SCROLL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ttcw_pkg::RAM_AW'(addr_r + AW'(ttcw_pkg::COLS));
      end
      ttcw_pkg::OP_SCROLL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r[ttcw_pkg::RAM_AW-1:0];
        ram_wdata = ram_rdata;
        addr_nxt  = addr_r + AW'(1);
      end
      ttcw_pkg::OP_BOTTOM_INIT: begin
        cur_row_nxt = RW'(ttcw_pkg::ROWS - 1);
        addr_nxt    = AW'((ttcw_pkg::ROWS - 1) * ttcw_pkg::COLS);
        lim_nxt     = AW'(ttcw_pkg::TOTAL);
      end
      ttcw_pkg::OP_CLEAR_STEP: begin
        if (addr_r != lim_r) begin
          ram_we    = 1'b1;
          ram_waddr = addr_r[ttcw_pkg::RAM_AW-1:0];
          ram_wdata = '0;
          addr_nxt  = addr_r + AW'(1);
        end
      end
      ttcw_pkg::OP_PUT: begin
        if (!is_ctrl) begin
          ram_we    = 1'b1;
          ram_waddr = put_addr[ttcw_pkg::RAM_AW-1:0];
          ram_wdata = {item_color_r, item_char_r};
        end
        priority if (is_newline) begin
          // Clear the rest of this row and all of the next one in one sweep.
          addr_nxt    = put_addr;
          lim_nxt     = line_lim;
          cur_col_nxt = '0;
          cur_row_nxt = cur_row_r + RW'(1);
        end else if (!is_ctrl && col_eff == CW'(ttcw_pkg::COLS - 1)) begin
          addr_nxt    = row_next_base;
          lim_nxt     = line_lim;
          cur_col_nxt = '0;
          cur_row_nxt = cur_row_r + RW'(1);
        end else if (is_return) begin
          cur_col_nxt = '0;
        end else if (is_backspace) begin
          cur_col_nxt = (col_eff == '0) ? '0 : col_eff - CW'(1);
        end else begin
          cur_col_nxt = col_eff + CW'(1);
        end
      end
      ttcw_pkg::OP_LOAD_OUT: begin
        out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      addr_r      <= '0;
      lim_r       <= AW'(ttcw_pkg::TOTAL);
      out_valid_r <= 1'b0;
    end else begin
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      addr_r      <= addr_nxt;
      lim_r       <= lim_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_char_r  <= res_char_nxt;
    res_color_r <= res_color_nxt;
    res_err_r   <= res_err_nxt;
    if (cmd.op == ttcw_pkg::OP_LATCH) begin
      item_action_r <= in_action;
      item_char_r   <= in_char_code;
      item_color_r  <= in_color;
      item_col_r    <= in_pos_col;
      item_row_r    <= in_pos_row;
    end
    if (cmd.op == ttcw_pkg::OP_LOAD_OUT) begin
      out_char_r  <= res_char_r;
      out_color_r <= res_color_r;
      out_col_r   <= cur_col_r;
      out_row_r   <= cur_row_r;
      out_err_r   <= res_err_r;
    end
  end

  ttcw_ram #(
    .WIDTH (ttcw_pkg::CELL_W),
    .DEPTH (ttcw_pkg::TOTAL)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.action         = ttcw_pkg::act_t'(item_action_r);
    sts.on_screen      = on_screen;
    sts.scroll_pending = (cur_row_r == RW'(ttcw_pkg::ROWS));
    sts.sweep_done     = (addr_r == lim_r);
    sts.put_clears     = is_newline | (~is_ctrl & (col_eff == CW'(ttcw_pkg::COLS - 1)));
    sts.out_free       = ~out_valid_r | out_ready;
    sts.cur_col        = cur_col_r;
    sts.cur_row        = cur_row_r;
  end

  assign out_valid          = out_valid_r;
  assign out_cell_char      = out_char_r;
  assign out_cell_color     = out_color_r;
  assign out_cursor_col     = out_col_r;
  assign out_cursor_row     = out_row_r;
  assign out_position_error = out_err_r;

endmodule

// ===== src/ttcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttcw_ctrl
// Controller: sequences the datapath through one action at a time.
// ----------------------------------------------------------------------------
module ttcw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ttcw_pkg::sts_t sts,
  output ttcw_pkg::cmd_t cmd
);

  typedef enum logic [10:0] {
    S_BOOT      = 11'b00000000001,
    S_IDLE      = 11'b00000000010,
    S_DECODE    = 11'b00000000100,
    S_SCROLL_RD = 11'b00000001000,
    S_SCROLL_WR = 11'b00000010000,
    S_CLR_BOT   = 11'b00000100000,
    S_PUT       = 11'b00001000000,
    S_CLR_LINE  = 11'b00010000000,
    S_CLR_ALL   = 11'b00100000000,
    S_READ_WAIT = 11'b01000000000,
    S_DONE      = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = ttcw_pkg::OP_NONE;
    in_ready  = 1'b0;

    unique case (state_r)
      S_BOOT: begin
        cmd.op = ttcw_pkg::OP_CLEAR_STEP;
        if (sts.sweep_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = ttcw_pkg::OP_LATCH;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.action)
          ttcw_pkg::ACT_PUT: begin
            if (sts.scroll_pending) begin
              cmd.op    = ttcw_pkg::OP_SCROLL_INIT;
              state_nxt = S_SCROLL_RD;
            end else begin
              state_nxt = S_PUT;
            end
          end
          ttcw_pkg::ACT_POS: begin
            cmd.op    = ttcw_pkg::OP_POS_WRITE;
            state_nxt = S_DONE;
          end
          ttcw_pkg::ACT_SETC: begin
            cmd.op    = ttcw_pkg::OP_SET_CURSOR;
            state_nxt = S_DONE;
          end
          ttcw_pkg::ACT_CLEAR: begin
            cmd.op    = ttcw_pkg::OP_CLEAR_ALL;
            state_nxt = S_CLR_ALL;
          end
          ttcw_pkg::ACT_READ: begin
            cmd.op    = ttcw_pkg::OP_READ_REQ;
            state_nxt = sts.on_screen ? S_READ_WAIT : S_DONE;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SCROLL_RD: begin
        if (sts.sweep_done) begin
          cmd.op    = ttcw_pkg::OP_BOTTOM_INIT;
          state_nxt = S_CLR_BOT;
        end else begin
          cmd.op    = ttcw_pkg::OP_SCROLL_RD;
          state_nxt = S_SCROLL_WR;
        end
      end
      S_SCROLL_WR: begin
        cmd.op    = ttcw_pkg::OP_SCROLL_WR;
        state_nxt = S_SCROLL_RD;
      end
      S_CLR_BOT: begin
        cmd.op = ttcw_pkg::OP_CLEAR_STEP;
        if (sts.sweep_done) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        cmd.op    = ttcw_pkg::OP_PUT;
        state_nxt = sts.put_clears ? S_CLR_LINE : S_DONE;
      end
      S_CLR_LINE, S_CLR_ALL: begin
        cmd.op = ttcw_pkg::OP_CLEAR_STEP;
        if (sts.sweep_done) begin
          state_nxt = S_DONE;
        end
      end
      S_READ_WAIT: begin
        cmd.op    = ttcw_pkg::OP_READ_CAP;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.op    = ttcw_pkg::OP_LOAD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BOOT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/text_terminal_cursor_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_terminal_cursor_writer_core
// Text-mode character screen store with a cursor and lazy scrolling.
// ----------------------------------------------------------------------------
// Each word on in_ch carries one action: put at cursor, put at position, set
// cursor, clear screen or read cell. Each action returns exactly one word on
// out_ch with the cell read (zero otherwise), the cursor after the action
// and a position error flag. Actions are handled one at a time.
// From accept, put at position, set cursor, an off-screen read or an
// undefined action pass through DECODE and DONE to out_ch.valid; a cell
// read also passes READ_WAIT and a put that clears nothing passes PUT. The
// next word is taken in the cycle after the result is loaded.
// A newline or a wrap sweeps up to two rows, one cell per cycle through the
// single write port of the screen memory. Clear screen sweeps all ROWS*COLS
// cells. A pending scroll copies (ROWS-1)*COLS cells, each by a read, then a
// write, and clears the bottom row before the put.
// After reset a clearing pass over all ROWS*COLS cells zeroes the screen;
// in_ch stays not ready until it ends. A finished result sits in an output
// register; the next word is taken while it waits, and the block holds
// that next result until out_ch has taken the earlier one.
// ----------------------------------------------------------------------------
module text_terminal_cursor_writer_core (
  input  logic        clk,
  input  logic        rst_n,
  ttcw_in_if.sink     in_ch,
  ttcw_out_if.source  out_ch
);

  ttcw_pkg::cmd_t cmd;
  ttcw_pkg::sts_t sts;

  ttcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ttcw_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_ch.action),
    .in_char_code       (in_ch.char_code),
    .in_color           (in_ch.color),
    .in_pos_col         (in_ch.pos_col),
    .in_pos_row         (in_ch.pos_row),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_cell_char      (out_ch.cell_char),
    .out_cell_color     (out_ch.cell_color),
    .out_cursor_col     (out_ch.cursor_col),
    .out_cursor_row     (out_ch.cursor_row),
    .out_position_error (out_ch.position_error)
  );

  // Only one word is in flight: an accept closes the input side.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted twice in a row");

  // A result is never loaded over one that out_ch has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == ttcw_pkg::OP_LOAD_OUT |-> !out_ch.valid || out_ch.ready)
    else $error("result register overwritten");

  // The cursor stays on screen, with the row one past the end only while a
  // scroll is pending.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    sts.cur_col < ttcw_pkg::COLS && sts.cur_row <= ttcw_pkg::ROWS)
    else $error("cursor out of range");

  // A loaded result carries the cursor of the cycle before.
  a_cursor_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == ttcw_pkg::OP_LOAD_OUT |=>
      out_ch.cursor_col == $past(sts.cur_col) && out_ch.cursor_row == $past(sts.cur_row))
    else $error("result cursor mismatch");

endmodule
